FILE: rtl/att_pkg.sv
// Package for the ANSI text terminal engine: sizes, character codes,
// cell layout and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package att_pkg;

  localparam int COLS_DEF    = 80;
  localparam int ROWS_DEF    = 25;
  localparam int MAX_CSI_DEF = 10;

  // internal cursor widths cover the full parameter ranges
  localparam int ROW_W = 6;
  localparam int COL_W = 7;

  // port field widths
  localparam int CH_W  = 8;
  localparam int RR_W  = 5;
  localparam int RC_W  = 7;
  localparam int CLR_W = 3;
  localparam int VAL_W = 16;

  localparam logic [VAL_W-1:0] VAL_MAX = 16'hFFFF;

  localparam logic [CH_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_BS    = 8'h08;
  localparam logic [CH_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [CH_W-1:0] CH_SP    = 8'h20;
  localparam logic [CH_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_7     = 8'h37;
  localparam logic [CH_W-1:0] CH_8     = 8'h38;
  localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CH_W-1:0] CH_LBR   = 8'h5B;
  localparam logic [CH_W-1:0] CH_M     = 8'h6D;
  localparam logic [CH_W-1:0] CH_D     = 8'h44;
  localparam logic [CH_W-1:0] CH_C     = 8'h43;
  localparam logic [CH_W-1:0] CH_H     = 8'h48;
  localparam logic [CH_W-1:0] CH_F     = 8'h66;
  localparam logic [CH_W-1:0] CH_J     = 8'h4A;

  localparam logic [VAL_W-1:0] SGR_FG_LO  = 16'd30;
  localparam logic [VAL_W-1:0] SGR_FG_HI  = 16'd37;
  localparam logic [VAL_W-1:0] SGR_BG_LO  = 16'd40;
  localparam logic [VAL_W-1:0] SGR_BG_HI  = 16'd47;
  localparam logic [VAL_W-1:0] SGR_FG_DEF = 16'd39;
  localparam logic [VAL_W-1:0] SGR_BG_DEF = 16'd49;
  localparam logic [VAL_W-1:0] ED_ALL     = 16'd2;

  localparam logic [CLR_W-1:0] FG_RESET = 3'd7;
  localparam logic [CLR_W-1:0] BG_RESET = 3'd0;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  typedef struct packed {
    logic [CLR_W-1:0] bg;
    logic [CLR_W-1:0] fg;
    logic [CH_W-1:0]  chr;
  } cell_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic cell_cap;
    logic fill_en;
    logic scroll_en;
    logic sgr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_scroll;
    logic need_fill;
    logic need_sgr;
    logic fill_end;
    logic scroll_end;
    logic sgr_end;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/att_in_if.sv
// Input channel interface: valid/ready handshake with the item payload.
// Depends on att_pkg.
`default_nettype none
interface att_in_if import att_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [CH_W-1:0] ch;
  logic [RR_W-1:0] read_row;
  logic [RC_W-1:0] read_col;

  modport source  (output valid, op, ch, read_row, read_col, input ready);
  modport sink    (input valid, op, ch, read_row, read_col, output ready);
  modport monitor (input valid, ready, op, ch, read_row, read_col);
endinterface
`default_nettype wire

FILE: rtl/att_out_if.sv
// Output channel interface: valid/ready handshake with the result payload.
// Depends on att_pkg.
`default_nettype none
interface att_out_if import att_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  cell_char;
  logic [CLR_W-1:0] cell_fg;
  logic [CLR_W-1:0] cell_bg;
  logic [RR_W-1:0]  cur_row;
  logic [RC_W-1:0]  cur_col;

  modport source  (output valid, cell_char, cell_fg, cell_bg, cur_row, cur_col, input ready);
  modport sink    (input valid, cell_char, cell_fg, cell_bg, cur_row, cur_col, output ready);
  modport monitor (input valid, ready, cell_char, cell_fg, cell_bg, cur_row, cur_col);
endinterface
`default_nettype wire

FILE: rtl/ansi_text_terminal_engine.sv
// Per transaction: a character passes accept, decode and hand-off; a cell read adds a
// capture step for the registered store read; the result is valid the cycle after hand-off.
// SGR adds a walk over its parameters; a scroll and a 2J clear each sweep the whole store.
// Throughput: one transaction at a time; a stalled result holds the engine in hand-off.
// Reset: asynchronous, active low; afterwards a clearing pass writes blank cells to the
// store with input ready held low.
// Depends on att_pkg, att_in_if, att_out_if, att_ctrl and att_dp.
`default_nettype none
module ansi_text_terminal_engine import att_pkg::*; #(
  parameter int COLS    = COLS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int MAX_CSI = MAX_CSI_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  att_in_if.sink     in_i,
  att_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  att_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_i.valid && in_ready),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  att_dp #(
    .COLS    (COLS),
    .ROWS    (ROWS),
    .MAX_CSI (MAX_CSI)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (in_i.op),
    .ch_i        (in_i.ch),
    .read_row_i  (in_i.read_row),
    .read_col_i  (in_i.read_col),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cell_char_o (out_o.cell_char),
    .cell_fg_o   (out_o.cell_fg),
    .cell_bg_o   (out_o.cell_bg),
    .cur_row_o   (out_o.cur_row),
    .cur_col_o   (out_o.cur_col)
  );

endmodule
`default_nettype wire

FILE: rtl/att_ctrl.sv
// Controller state machine of the terminal engine: sequences init clear,
// decode, reads, scroll/fill sweeps, SGR walk and result hand-off. Uses att_pkg.
`default_nettype none
module att_ctrl import att_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_acc_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_SGR    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill_en = 1'b1;
        if (sts_i.fill_end) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_read)          state_d = S_READ;
        else if (sts_i.need_scroll) state_d = S_SCROLL;
        else if (sts_i.need_fill)   state_d = S_FILL;
        else if (sts_i.need_sgr)    state_d = S_SGR;
        else                        state_d = S_DONE;
      end
      S_READ: begin
        cmd_o.cell_cap = 1'b1;
        state_d        = S_DONE;
      end
      S_SCROLL: begin
        cmd_o.scroll_en = 1'b1;
        if (sts_i.scroll_end) state_d = S_DONE;
      end
      S_FILL: begin
        cmd_o.fill_en = 1'b1;
        if (sts_i.fill_end) state_d = S_DONE;
      end
      S_SGR: begin
        cmd_o.sgr_step = 1'b1;
        if (sts_i.sgr_end) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_acc_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_acc_i) |=> state_q == S_EXEC)
    else $error("accepted transaction did not start decode");
  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && sts_i.is_read) |=> state_q == S_READ)
    else $error("cell read did not wait for memory data");
  a_scroll_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL && sts_i.scroll_end) |=> state_q == S_DONE)
    else $error("scroll sweep did not finish");

endmodule
`default_nettype wire

FILE: rtl/att_dp.sv
// Datapath of the terminal engine: screen store, cursor, colours, escape
// parser registers, sweep counters and the output register. Uses att_pkg.
`default_nettype none
module att_dp import att_pkg::*; #(
  parameter int COLS    = COLS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int MAX_CSI = MAX_CSI_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  wire               op_i,
  input  wire  [CH_W-1:0]   ch_i,
  input  wire  [RR_W-1:0]   read_row_i,
  input  wire  [RC_W-1:0]   read_col_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [CH_W-1:0]   cell_char_o,
  output logic [CLR_W-1:0]  cell_fg_o,
  output logic [CLR_W-1:0]  cell_bg_o,
  output logic [RR_W-1:0]   cur_row_o,
  output logic [RC_W-1:0]   cur_col_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int LAST  = (ROWS - 1) * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int IW    = $clog2(MAX_CSI);

  // item registers
  logic            op_q;
  logic [CH_W-1:0] ch_q;
  logic [RR_W-1:0] rr_q;
  logic [RC_W-1:0] rc_q;

  logic [ROW_W-1:0] row_q, row_d, srow_q, srow_d;
  logic [COL_W-1:0] col_q, col_d, scol_q, scol_d;
  logic [CLR_W-1:0] fg_q, bg_q, fg_d, bg_d;
  logic [1:0]       mode_q, mode_d;
  logic [VAL_W-1:0] vals_q [MAX_CSI];
  logic [VAL_W-1:0] vals_d [MAX_CSI];
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    sgr_i_q;
  logic [CW-1:0]    cnt_q;

  cell_t            mem [CELLS];
  cell_t            rd_q, cell_q, wd, blank;
  logic             we;
  logic [AW-1:0]    wa, ra;

  cell_t            out_cell_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;
  logic             out_valid_q;

  // decode results
  logic             put;
  logic [CH_W-1:0]  put_chr;
  logic [ROW_W-1:0] put_row, sb_row;
  logic [COL_W-1:0] put_col, sb_col;
  logic             sb_ok, in_rng, is_read, need_scroll, need_fill, need_sgr;
  logic [VAL_W-1:0] n_mv, cur_val;
  logic [19:0]      prod;
  logic [16:0]      col_sum;
  logic [AW-1:0]    put_addr, rd_addr;

  assign blank = '{bg: bg_q, fg: fg_q, chr: CH_SP};
  assign in_rng = ({1'b0, rr_q} < ROWS) && ({1'b0, rc_q} < COLS);

  // one step back, wrapping to the end of the previous row
  always_comb begin
    sb_ok  = 1'b1;
    sb_row = row_q;
    sb_col = col_q;
    if (col_q != '0) begin
      sb_col = col_q - 1'b1;
    end else if (row_q != '0) begin
      sb_row = row_q - 1'b1;
      sb_col = COL_W'(COLS - 1);
    end else begin
      sb_ok = 1'b0;
    end
  end

  assign cur_val = vals_q[idx_q];
  assign prod    = 20'(cur_val) * 20'd10 + 20'((ch_q - CH_0) & 8'h0F);
  assign n_mv    = (vals_q[0] == '0) ? 16'd1 : vals_q[0];
  assign col_sum = 17'(col_q) + 17'(n_mv);

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    srow_d      = srow_q;
    scol_d      = scol_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    vals_d      = vals_q;
    put         = 1'b0;
    put_chr     = ch_q;
    put_row     = row_q;
    put_col     = col_q;
    is_read     = 1'b0;
    need_scroll = 1'b0;
    need_fill   = 1'b0;
    need_sgr    = 1'b0;
    if (op_q) begin
      is_read = in_rng;
    end else if (mode_q == MODE_ESC) begin
      mode_d = MODE_NORMAL;
      if (ch_q == CH_7) begin
        srow_d = row_q;
        scol_d = col_q;
      end else if (ch_q == CH_8) begin
        row_d = srow_q;
        col_d = scol_q;
      end else if (ch_q == CH_LBR) begin
        for (int i = 0; i < MAX_CSI; i++) vals_d[i] = '0;
        idx_d  = '0;
        mode_d = MODE_CSI;
      end
    end else if (mode_q == MODE_CSI) begin
      if (ch_q >= CH_0 && ch_q <= CH_9) begin
        vals_d[idx_q] = (prod > 20'(VAL_MAX)) ? VAL_MAX : prod[VAL_W-1:0];
      end else if (ch_q == CH_SEMI) begin
        if (idx_q < IW'(MAX_CSI - 1)) idx_d = idx_q + 1'b1;
      end else begin
        mode_d = MODE_NORMAL;
        if (ch_q == CH_M) begin
          need_sgr = 1'b1;
        end else if (ch_q == CH_D) begin
          col_d = (n_mv >= 16'(col_q)) ? '0 : col_q - n_mv[COL_W-1:0];
        end else if (ch_q == CH_C) begin
          col_d = (col_sum >= 17'(COLS)) ? COL_W'(COLS - 1) : col_sum[COL_W-1:0];
        end else if (ch_q == CH_H || ch_q == CH_F) begin
          row_d = (vals_q[0] >= 16'(ROWS)) ? ROW_W'(ROWS - 1) : vals_q[0][ROW_W-1:0];
          col_d = (vals_q[1] >= 16'(COLS)) ? COL_W'(COLS - 1) : vals_q[1][COL_W-1:0];
        end else if (ch_q == CH_J) begin
          if (vals_q[0] == ED_ALL) begin
            need_fill = 1'b1;
            row_d     = '0;
            col_d     = '0;
          end
        end
      end
    end else begin
      if (ch_q == CH_ESC) begin
        mode_d = MODE_ESC;
      end else if (ch_q == CH_LF) begin
        if (({1'b0, row_q} + 1'b1) >= ROWS) need_scroll = 1'b1;
        else row_d = row_q + 1'b1;
      end else if (ch_q == CH_DEL) begin
        if (sb_ok) begin
          put     = 1'b1;
          put_chr = CH_SP;
          put_row = sb_row;
          put_col = sb_col;
          row_d   = sb_row;
          col_d   = sb_col;
        end
      end else if (ch_q == CH_BS) begin
        row_d = sb_row;
        col_d = sb_col;
      end else if (ch_q == CH_CR) begin
        col_d = '0;
      end else if (ch_q >= CH_SP && ch_q <= CH_TILDE) begin
        put = 1'b1;
        if (({1'b0, col_q} + 1'b1) >= COLS) begin
          col_d = '0;
          if (({1'b0, row_q} + 1'b1) >= ROWS) need_scroll = 1'b1;
          else row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  // SGR walk, one parameter a cycle
  always_comb begin
    logic [VAL_W-1:0] p;
    p    = vals_q[sgr_i_q];
    fg_d = fg_q;
    bg_d = bg_q;
    if (p >= SGR_FG_LO && p <= SGR_FG_HI)      fg_d = p[CLR_W-1:0] - SGR_FG_LO[CLR_W-1:0];
    else if (p >= SGR_BG_LO && p <= SGR_BG_HI) bg_d = p[CLR_W-1:0] - SGR_BG_LO[CLR_W-1:0];
    else if (p == SGR_FG_DEF)                  fg_d = FG_RESET;
    else if (p == SGR_BG_DEF)                  bg_d = BG_RESET;
  end

  assign put_addr = AW'(int'(put_row) * COLS + int'(put_col));
  assign rd_addr  = in_rng ? AW'(int'(rr_q) * COLS + int'(rc_q)) : '0;

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = blank;
    ra = rd_addr;
    if (cmd_i.exec && put) begin
      we = 1'b1;
      wa = put_addr;
      wd = '{bg: bg_q, fg: fg_q, chr: put_chr};
    end else if (cmd_i.fill_en) begin
      we = 1'b1;
      wa = cnt_q[AW-1:0];
    end else if (cmd_i.scroll_en) begin
      ra = (cnt_q < CW'(LAST)) ? AW'(int'(cnt_q) + COLS) : '0;
      if (cnt_q != '0) begin
        we = 1'b1;
        wa = AW'(cnt_q - 1'b1);
        wd = (cnt_q <= CW'(LAST)) ? rd_q : blank;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      ch_q <= ch_i;
      rr_q <= read_row_i;
      rc_q <= read_col_i;
    end
    if (cmd_i.exec)          cell_q <= '0;
    else if (cmd_i.cell_cap) cell_q <= rd_q;
    if (cmd_i.out_load) begin
      out_cell_q <= cell_q;
      out_row_q  <= row_q;
      out_col_q  <= col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      srow_q      <= '0;
      scol_q      <= '0;
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
      mode_q      <= MODE_NORMAL;
      idx_q       <= '0;
      for (int i = 0; i < MAX_CSI; i++) vals_q[i] <= '0;
      sgr_i_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        row_q  <= row_d;
        col_q  <= col_d;
        srow_q <= srow_d;
        scol_q <= scol_d;
        mode_q <= mode_d;
        idx_q  <= idx_d;
        vals_q <= vals_d;
      end
      if (cmd_i.sgr_step) begin
        fg_q    <= fg_d;
        bg_q    <= bg_d;
        sgr_i_q <= sgr_i_q + 1'b1;
      end else begin
        sgr_i_q <= '0;
      end
      if (cmd_i.fill_en || cmd_i.scroll_en) cnt_q <= cnt_q + 1'b1;
      else                                  cnt_q <= '0;
      if (cmd_i.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.is_read     = is_read;
  assign sts_o.need_scroll = need_scroll;
  assign sts_o.need_fill   = need_fill;
  assign sts_o.need_sgr    = need_sgr;
  assign sts_o.fill_end    = (cnt_q == CW'(CELLS - 1));
  assign sts_o.scroll_end  = (cnt_q == CW'(CELLS));
  assign sts_o.sgr_end     = (sgr_i_q == idx_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign cell_char_o = out_cell_q.chr;
  assign cell_fg_o   = out_cell_q.fg;
  assign cell_bg_o   = out_cell_q.bg;
  assign cur_row_o   = out_row_q[RR_W-1:0];
  assign cur_col_o   = out_col_q[RC_W-1:0];

endmodule
`default_nettype wire

FILE: tb/sv/att_char_checker.sv
// Checker for the ANSI text terminal engine: watches both channels, predicts
// cell reads and cursor positions, compares each result transaction.
// Depends on att_pkg, att_in_if and att_out_if.
`timescale 1ns / 100ps
module att_char_checker import att_pkg::*; #(
  parameter int COLS    = COLS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int MAX_CSI = MAX_CSI_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  att_in_if.monitor   in_mon,
  att_out_if.monitor  out_mon,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [CH_W-1:0]  chr;
    logic [CLR_W-1:0] fg;
    logic [CLR_W-1:0] bg;
    logic [RR_W-1:0]  row;
    logic [RC_W-1:0]  col;
  } term_result_t;

  cell_t            screen [ROWS*COLS];
  int unsigned      crow, ccol, srow, scol;
  logic [CLR_W-1:0] fgc, bgc;
  logic [1:0]       mode;
  int unsigned      params [MAX_CSI];
  int unsigned      pidx;
  term_result_t     expected_q [$];

  function automatic cell_t blank();
    cell_t b;
    b.chr = CH_SP; b.fg = fgc; b.bg = bgc;
    return b;
  endfunction

  task automatic shift_screen_up();
    for (int i = 0; i < (ROWS-1)*COLS; i++) screen[i] = screen[i+COLS];
    for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) screen[i] = blank();
    if (crow > 0) crow--;
  endtask

  task automatic line_down();
    crow++;
    if (crow >= ROWS) shift_screen_up();
  endtask

  task automatic draw(logic [CH_W-1:0] c);
    cell_t w;
    w.chr = c; w.fg = fgc; w.bg = bgc;
    screen[crow*COLS+ccol] = w;
    ccol++;
    if (ccol >= COLS) begin
      ccol = 0;
      line_down();
    end
  endtask

  function automatic bit back_one();
    if (ccol > 0) begin
      ccol--;
      return 1;
    end
    if (crow > 0) begin
      crow--;
      ccol = COLS-1;
      return 1;
    end
    return 0;
  endfunction

  task automatic terminal_step(logic op, logic [CH_W-1:0] c, int unsigned rr,
                               int unsigned rc);
    term_result_t r;
    int unsigned  n, v;
    bit           dummy;
    r = '0;
    if (op) begin
      if (rr < ROWS && rc < COLS) begin
        r.chr = screen[rr*COLS+rc].chr;
        r.fg  = screen[rr*COLS+rc].fg;
        r.bg  = screen[rr*COLS+rc].bg;
      end
    end else if (mode == MODE_ESC) begin
      mode = MODE_NORMAL;
      if (c == CH_7) begin
        srow = crow; scol = ccol;
      end else if (c == CH_8) begin
        crow = srow; ccol = scol;
      end else if (c == CH_LBR) begin
        foreach (params[i]) params[i] = 0;
        pidx = 0;
        mode = MODE_CSI;
      end
    end else if (mode == MODE_CSI) begin
      if (c >= CH_0 && c <= CH_9) begin
        v = params[pidx]*10 + (c - CH_0);
        params[pidx] = (v > VAL_MAX) ? VAL_MAX : v;
      end else if (c == CH_SEMI) begin
        if (pidx < MAX_CSI-1) pidx++;
      end else begin
        n = (params[0] == 0) ? 1 : params[0];
        if (c == CH_M) begin
          for (int i = 0; i <= pidx; i++) begin
            if (params[i] >= SGR_FG_LO && params[i] <= SGR_FG_HI)
              fgc = CLR_W'(params[i] - SGR_FG_LO);
            else if (params[i] >= SGR_BG_LO && params[i] <= SGR_BG_HI)
              bgc = CLR_W'(params[i] - SGR_BG_LO);
            else if (params[i] == SGR_FG_DEF) fgc = FG_RESET;
            else if (params[i] == SGR_BG_DEF) bgc = BG_RESET;
          end
        end else if (c == CH_D) begin
          ccol = (n >= ccol) ? 0 : ccol - n;
        end else if (c == CH_C) begin
          ccol = (ccol + n >= COLS) ? COLS-1 : ccol + n;
        end else if (c == CH_H || c == CH_F) begin
          crow = (params[0] >= ROWS) ? ROWS-1 : params[0];
          ccol = (params[1] >= COLS) ? COLS-1 : params[1];
        end else if (c == CH_J && params[0] == ED_ALL) begin
          foreach (screen[i]) screen[i] = blank();
          crow = 0; ccol = 0;
        end
        mode = MODE_NORMAL;
      end
    end else begin
      if (c == CH_ESC) mode = MODE_ESC;
      else if (c == CH_LF) line_down();
      else if (c == CH_DEL) begin
        if (back_one()) begin
          draw(CH_SP);
          dummy = back_one();
        end
      end else if (c == CH_BS) dummy = back_one();
      else if (c == CH_CR) ccol = 0;
      else if (c >= CH_SP && c <= CH_TILDE) draw(c);
    end
    r.row = RR_W'(crow);
    r.col = RC_W'(ccol);
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    crow = 0; ccol = 0; srow = 0; scol = 0;
    fgc = FG_RESET; bgc = BG_RESET; mode = MODE_NORMAL; pidx = 0;
    foreach (params[i]) params[i] = 0;
    foreach (screen[i]) screen[i] = blank();
  end

  always @(posedge clk_i) begin
    term_result_t e;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready)
        terminal_step(in_mon.op, in_mon.ch, in_mon.read_row, in_mon.read_col);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_mon.cell_char !== e.chr) report_mismatch("cell_char", out_mon.cell_char, e.chr);
          if (out_mon.cell_fg !== e.fg) report_mismatch("cell_fg", out_mon.cell_fg, e.fg);
          if (out_mon.cell_bg !== e.bg) report_mismatch("cell_bg", out_mon.cell_bg, e.bg);
          if (out_mon.cur_row !== e.row) report_mismatch("cur_row", out_mon.cur_row, e.row);
          if (out_mon.cur_col !== e.col) report_mismatch("cur_col", out_mon.cur_col, e.col);
        end
      end
      pending_count = expected_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_ansi_text_terminal_engine.sv
// Testbench top for the ANSI text terminal engine: drives character and
// cell-read transactions under varied idling; verdict from att_char_checker.
// Depends on att_pkg, att_in_if, att_out_if and the engine.
`timescale 1ns / 100ps
module tb_ansi_text_terminal_engine import att_pkg::*; ();

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending_count;
  int   send_idle_pct, recv_stall_pct;
  bit   stim_done;

  att_in_if  in_ch ();
  att_out_if out_ch ();

  ansi_text_terminal_engine DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  att_char_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch.monitor),
    .out_mon      (out_ch.monitor),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = 1'b0;
    in_ch.ch = '0;
    in_ch.read_row = '0;
    in_ch.read_col = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays high after an accept unless a gap follows or the bus is drained
  task automatic send(logic op, logic [CH_W-1:0] c, logic [RR_W-1:0] rr, logic [RC_W-1:0] rc);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.ch       <= c;
    in_ch.read_row <= rr;
    in_ch.read_col <= rc;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic put_char(logic [CH_W-1:0] c);
    send(1'b0, c, RR_W'($urandom), RC_W'($urandom));
  endtask

  task automatic put_text(string s);
    foreach (s[i]) put_char(s[i]);
  endtask

  task automatic read_cell(int rr, int rc);
    send(1'b1, CH_W'($urandom), RR_W'(rr), RC_W'(rc));
  endtask

  task automatic rand_csi();
    int k, sel;
    put_char(CH_ESC);
    put_char(CH_LBR);
    k = $urandom_range(3);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(9) == 0) put_text("99999");
      else put_text($sformatf("%0d", $urandom_range(1) ? $urandom_range(50) : $urandom_range(90)));
      if (i < k-1) put_char(CH_SEMI);
    end
    sel = $urandom_range(7);
    case (sel) inside
      [0:1]: put_char(CH_M);
      2: put_char(CH_D);
      3: put_char(CH_C);
      4: put_char(CH_H);
      5: put_char(CH_F);
      6: put_char(CH_J);
      default: put_char(CH_W'($urandom));
    endcase
  endtask

  task automatic random_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) read_cell($urandom_range(1) ? $urandom_range(ROWS_DEF-1) : $urandom_range(31),
                            $urandom_range(1) ? $urandom_range(COLS_DEF-1) : $urandom_range(127));
    else if (sel < 60) put_char(CH_W'($urandom_range(CH_SP, CH_TILDE)));
    else if (sel < 70) rand_csi();
    else if (sel < 74) begin
      put_char(CH_ESC);
      put_char($urandom_range(1) ? CH_7 : CH_8);
    end else if (sel < 85) begin
      case ($urandom_range(3))
        0: put_char(CH_LF);
        1: put_char(CH_CR);
        2: put_char(CH_BS);
        default: put_char(CH_DEL);
      endcase
    end else put_char(CH_W'($urandom));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edges, every command, odd cases
    read_cell(0, 0);
    read_cell(24, 79);
    read_cell(25, 0);
    read_cell(31, 127);
    put_char(CH_DEL);
    put_char(CH_BS);
    put_text("A~");
    put_char(8'hFF);
    put_char(8'h01);
    put_text("\033[31;42mX\033[39;49m");
    put_text("\033[99999999H");
    read_cell(24, 79);
    put_text("Z\033[2J");
    put_text("\033[1;2;3;4;5;6;7;8;9;10;11;12;33m");
    put_text("\033[5Cq\033[0D\033[3f\033[1J\033[2Q\033x\0337\n\0338");
    put_char(CH_DEL);
    put_char(CH_CR);
    read_cell(0, 0);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 210; i++) random_item();
      wait_drained();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait_drained();
    repeat (ROWS_DEF*COLS_DEF*2 + 20) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/att_pkg.sv
rtl/att_in_if.sv
rtl/att_out_if.sv
rtl/att_ctrl.sv
rtl/att_dp.sv
rtl/ansi_text_terminal_engine.sv
tb/sv/att_char_checker.sv
tb/sv/tb_ansi_text_terminal_engine.sv
